// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the tessellator RTL.
// Included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/core/pgwt_pkg.sv =====
// Types and constants for the plane grid wireframe tessellator.
// No dependencies.
package pgwt_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CellW  = 31;
  localparam int unsigned CntW   = 4;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_LINE   = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;

  // one edge component split by its count: |a| = q * count + r
  typedef struct packed {
    logic            neg;
    logic [31:0]     q;
    logic [CntW-1:0] r;
  } term_t;

  // one classified plane waiting for emission
  typedef struct packed {
    coord_t       ox, oy, oz;
    term_t        ux, uy, uz;
    term_t        vx, vy, vz;
    coord_t       nx, ny, nz;
    logic [CntW-1:0] n;
    logic [CntW-1:0] m;
  } job_t;
endpackage

// ===== rtl/core/pgwt_count.sv =====
// Front end: accepts planes, derives subdivision counts N and M, and divides
// the edge components by them. Depends on pgwt_pkg. Forms the
// squares via a 32x32 multiplier; six one-bit-per-cycle divider lanes.
module pgwt_count
  import pgwt_pkg::*;
#(
  parameter int unsigned MAX_DIV = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CellW-1:0]    cell_length,
  input  logic                in_valid,
  output logic                in_ready,
  input  coord_t              in_o [3],
  input  coord_t              in_u [3],
  input  coord_t              in_v [3],
  input  coord_t              in_n [3],
  output logic                job_valid,
  input  logic                job_ready,
  output job_t                job
);
  typedef enum logic [2:0] {S_IDLE, S_SQ, S_CMP, S_DINIT, S_DIV, S_OUT} state_t;
  state_t state;
  coord_t o [3];
  coord_t u [3];
  coord_t v [3];
  coord_t nrm [3];
  logic [2:0] sel;          // which component is squared (0..5)
  logic [65:0] su, sv;      // sums of squares
  logic [CntW-1:0] k;
  logic [CntW-1:0] cn, cm;
  logic [61:0] lsq;         // L^2
  logic [73:0] tt;          // ((2k-1)*L)^2
  logic [31:0] mag;
  coord_t comp;
  logic [63:0] sq;
  logic [31:0] dq [6];
  logic [CntW-1:0] rem [6];
  logic [4:0] bitc;
  logic [CntW-1:0] dvs [6];
  logic [CntW:0] trial [6];
  logic [5:0] take;
  logic [CntW-1:0] rem_next [6];
  logic [31:0] dq_next [6];

  function automatic logic [31:0] absval(input coord_t a);
    absval = a[31] ? 32'(-a) : 32'(a);
  endfunction

  function automatic term_t mk_term(input logic neg, input logic [31:0] q,
                                    input logic [CntW-1:0] r);
    term_t tm;
    tm.neg = neg;
    tm.q = q;
    tm.r = r;
    return tm;
  endfunction

  always_comb begin
    case (sel)
      3'd0: comp = u[0];
      3'd1: comp = u[1];
      3'd2: comp = u[2];
      3'd3: comp = v[0];
      3'd4: comp = v[1];
      default: comp = v[2];
    endcase
    mag = comp[31] ? 32'(-comp) : 32'(comp);
    sq  = 64'(mag) * 64'(mag);
  end

  // restoring divide step, lanes 0..2 by N and 3..5 by M
  always_comb begin
    for (int c = 0; c < 6; c++) begin
      dvs[c] = (c < 3) ? cn : cm;
      trial[c] = {rem[c], dq[c][31]};
      take[c] = trial[c] >= {1'b0, dvs[c]};
      rem_next[c] = take[c] ? CntW'(trial[c] - {1'b0, dvs[c]}) : trial[c][CntW-1:0];
      dq_next[c] = {dq[c][30:0], take[c]};
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            o <= in_o; u <= in_u; v <= in_v; nrm <= in_n;
            sel <= 3'd0; su <= '0; sv <= '0;
            lsq <= 62'(cell_length) * 62'(cell_length);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (sel < 3'd3) su <= su + 66'(sq);
          else sv <= sv + 66'(sq);
          if (sel == 3'd5) begin
            k <= CntW'(2); cn <= CntW'(1); cm <= CntW'(1);
            tt <= 74'(lsq);
            state <= (MAX_DIV >= 2) ? S_CMP : S_DINIT;
            sel <= 3'd6;
          end else begin
            sel <= sel + 3'd1;
          end
        end
        S_CMP: begin
          // advance the threshold square first, compare next cycle
          if (sel == 3'd6) begin
            tt <= tt + (74'(66'(lsq) * 66'(k - CntW'(1))) << 3);
            sel <= 3'd7;
          end else begin
            if (74'({su, 2'b00}) >= tt) cn <= k;
            if (74'({sv, 2'b00}) >= tt) cm <= k;
            if (32'(k) >= MAX_DIV) state <= S_DINIT;
            else begin
              k <= k + CntW'(1);
              sel <= 3'd6;
            end
          end
        end
        S_DINIT: begin
          for (int c = 0; c < 3; c++) begin
            dq[c] <= absval(u[c]);
            dq[c+3] <= absval(v[c]);
          end
          for (int c = 0; c < 6; c++) rem[c] <= '0;
          bitc <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < 6; c++) begin
            dq[c] <= dq_next[c];
            rem[c] <= rem_next[c];
          end
          bitc <= bitc + 5'd1;
          if (bitc == 5'd31) state <= S_OUT;
        end
        S_OUT: begin
          if (!job_valid) begin
            job <= '{ox: o[0], oy: o[1], oz: o[2],
                     ux: mk_term(u[0][31], dq[0], rem[0]),
                     uy: mk_term(u[1][31], dq[1], rem[1]),
                     uz: mk_term(u[2][31], dq[2], rem[2]),
                     vx: mk_term(v[0][31], dq[3], rem[3]),
                     vy: mk_term(v[1][31], dq[4], rem[4]),
                     vz: mk_term(v[2][31], dq[5], rem[5]),
                     nx: nrm[0], ny: nrm[1], nz: nrm[2], n: cn, m: cm};
            job_valid <= 1'b1;
          end else if (job_ready) begin
            job_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/pgwt_emit.sv =====
// Back end: walks vertices then lines of one plane, one record per cycle
// unless out_ready stalls it. Depends on pgwt_pkg; vertex terms use a 32x4
// multiply of the per-edge quotient plus a small rounding compare on the remainder.
module pgwt_emit
  import pgwt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_t         job,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         kind,
  output logic [31:0]  index_a,
  output logic [31:0]  index_b,
  output coord_t       pos_x,
  output coord_t       pos_y,
  output coord_t       pos_z,
  output coord_t       out_nx,
  output coord_t       out_ny,
  output coord_t       out_nz,
  output logic         last
);
  `include "assert_macros.svh"
  typedef enum logic [1:0] {E_IDLE, E_VTX, E_HOR, E_VER} phase_t;
  // E_VER also covers diagonals through a flag
  phase_t phase;
  job_t j;
  logic diag;
  logic [CntW-1:0] ci, cj;
  logic signed [CntW:0] dd;
  logic [31:0] base;
  logic [31:0] w;

  // round(i*a/d), halves away from zero, with |a| = q*d + r
  function automatic logic signed [33:0] rterm(input term_t a, input logic [CntW-1:0] i,
                                               input logic [CntW-1:0] d);
    logic [35:0] m;
    logic [9:0] x2;
    logic [CntW-1:0] f;
    m = 36'(a.q) * 36'(i);
    x2 = 10'(i) * 10'(a.r) * 10'd2 + 10'(d);
    f = '0;
    for (int k = 1; k < (1 << CntW); k++) begin
      if (x2 >= 10'(k) * 10'(d) * 10'd2) f = CntW'(k);
    end
    m = m + 36'(f);
    rterm = a.neg ? -34'(m) : 34'(m);
  endfunction

  function automatic coord_t sat(input logic signed [35:0] s);
    if (s > 36'sd2147483647) sat = 32'h7fffffff;
    else if (s < -36'sd2147483648) sat = 32'h80000000;
    else sat = coord_t'(s[31:0]);
  endfunction

  logic [31:0] ia, ib;
  logic islast;
  logic [CntW-1:0] is_, js_, ie_, je_;
  always_comb begin
    is_ = dd > 0 ? CntW'(dd) : '0;
    js_ = dd < 0 ? CntW'(-dd) : '0;
    ie_ = (5'(j.m) + dd) < 5'(j.n) ? CntW'(5'(j.m) + dd) : j.n;
    je_ = (5'(j.n) - dd) < 5'(j.m) ? CntW'(5'(j.n) - dd) : j.m;
    ia = '0; ib = '0; islast = 1'b0;
    case (phase)
      E_VTX: ia = base + 32'(ci) * w + 32'(cj);
      E_HOR: begin
        ia = base + 32'(cj);
        ib = base + 32'(j.n) * w + 32'(cj);
      end
      E_VER: begin
        if (!diag) begin
          ia = base + 32'(ci) * w;
          ib = ia + 32'(j.m);
          islast = (ci == j.n) && (j.m == 4'd1 && j.n == 4'd0);
        end else begin
          ia = base + 32'(is_) * w + 32'(js_);
          ib = base + 32'(ie_) * w + 32'(je_);
          islast = (dd == 5'(j.n) - 5'sd1);
        end
      end
      default: ;
    endcase
  end

  logic adv;
  assign adv = !out_valid || out_ready;
  assign job_ready = (phase == E_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= E_IDLE;
      out_valid <= 1'b0;
      base <= '0;
    end else begin
      // drop the last record of a plane once it is taken
      if (phase == E_IDLE && out_ready) out_valid <= 1'b0;
      case (phase)
        E_IDLE: if (job_valid) begin
          j <= job; ci <= '0; cj <= '0; diag <= 1'b0;
          w <= 32'(job.m) + 32'd1;
          phase <= E_VTX;
        end
        E_VTX: if (adv) begin
          out_valid <= 1'b1; kind <= KIND_VERTEX; last <= 1'b0;
          index_a <= ia; index_b <= '0;
          pos_x <= sat(36'(j.ox) + 36'(rterm(j.ux, ci, j.n)) + 36'(rterm(j.vx, cj, j.m)));
          pos_y <= sat(36'(j.oy) + 36'(rterm(j.uy, ci, j.n)) + 36'(rterm(j.vy, cj, j.m)));
          pos_z <= sat(36'(j.oz) + 36'(rterm(j.uz, ci, j.n)) + 36'(rterm(j.vz, cj, j.m)));
          out_nx <= j.nx; out_ny <= j.ny; out_nz <= j.nz;
          if (cj == j.m) begin
            cj <= '0;
            if (ci == j.n) phase <= E_HOR;
            else ci <= ci + CntW'(1);
          end else cj <= cj + CntW'(1);
        end
        E_HOR: if (adv) begin
          out_valid <= 1'b1; kind <= KIND_LINE; last <= 1'b0;
          index_a <= ia; index_b <= ib;
          pos_x <= '0; pos_y <= '0; pos_z <= '0;
          out_nx <= '0; out_ny <= '0; out_nz <= '0;
          if (cj == j.m) begin
            phase <= E_VER; ci <= '0;
          end else cj <= cj + CntW'(1);
        end
        E_VER: if (adv) begin
          out_valid <= 1'b1; kind <= KIND_LINE;
          index_a <= ia; index_b <= ib;
          last <= diag && islast;
          if (!diag) begin
            if (ci == j.n) begin
              diag <= 1'b1;
              dd <= 5'sd1 - 5'(j.m);
            end else ci <= ci + CntW'(1);
          end else if (islast) begin
            base <= base + 32'(5'(j.n) + 5'd1) * w;
            phase <= E_IDLE;
          end else dd <= dd + 5'sd1;
        end
        default: phase <= E_IDLE;
      endcase
    end
  end

  `CHK_IMPL(a_line_zero_pos, clk, rst, out_valid && kind == KIND_LINE, pos_x == '0)
  `CHK_IMPL(a_vtx_no_last, clk, rst, out_valid && kind == KIND_VERTEX, !last)
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(index_a))
endmodule

// ===== rtl/core/plane_grid_wireframe_tessellator.sv =====
// Plane grid wireframe tessellator: each accepted plane yields (N+1)(M+1)
// vertex records followed by M+1 horizontal, N+1 vertical and N+M-1 diagonal
// line records, one per cycle while out_ready is high, the final one flagged
// last; at N = M = 5 that is 57 records. The front end works through a plane
// in order: it takes the plane in, forms six squares through one multiplier,
// runs each count step as a threshold advance and a compare, loads and then
// divides the edge components by the counts, and hands the job over. A
// one-entry queue lets the next plane be counted while the back end emits;
// the back end loads a job and then emits its records.
// Depends on pgwt_pkg, pgwt_count, pgwt_emit.
module plane_grid_wireframe_tessellator
  import pgwt_pkg::*;
#(
  parameter int unsigned MAX_DIV = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CellW-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  coord_t origin_x, origin_y, origin_z,
  input  coord_t edge_u_x, edge_u_y, edge_u_z,
  input  coord_t edge_v_x, edge_v_y, edge_v_z,
  input  coord_t face_nx, face_ny, face_nz,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              kind,
  output logic [31:0]       index_a,
  output logic [31:0]       index_b,
  output coord_t            pos_x, pos_y, pos_z,
  output coord_t            out_nx, out_ny, out_nz,
  output logic              last
);
  logic [CellW-1:0] cell_length;
  logic job_valid, job_ready;
  job_t job;

  always_ff @(posedge clk) begin
    if (rst) cell_length <= CellW'(65536);
    else if (cfg_we) cell_length <= cfg_wdata;
  end

  pgwt_count #(.MAX_DIV(MAX_DIV)) u_count (
    .clk, .rst, .cell_length, .in_valid, .in_ready,
    .in_o('{origin_x, origin_y, origin_z}),
    .in_u('{edge_u_x, edge_u_y, edge_u_z}),
    .in_v('{edge_v_x, edge_v_y, edge_v_z}),
    .in_n('{face_nx, face_ny, face_nz}),
    .job_valid, .job_ready, .job
  );

  pgwt_emit u_emit (
    .clk, .rst, .job_valid, .job_ready, .job, .out_valid, .out_ready,
    .kind, .index_a, .index_b, .pos_x, .pos_y, .pos_z,
    .out_nx, .out_ny, .out_nz, .last
  );
endmodule
